### src/bsq_pkg.sv
// Shared types and constants for the bounded sequence store.
// Used by the top level, the controller and the datapath; no dependencies of its own.
`timescale 1ns / 1ps

package bsq_pkg;

  // Field widths of the request and response transfers
  localparam int CMD_W = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int CAP_W = 7;

  // Build defaults
  localparam int DEPTH_DEFAULT      = 64;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Capacity register after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Operation codes
  localparam logic [CMD_W-1:0] CMD_INSERT_SORTED = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT_AT     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ERASE_AT      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE_EQUAL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GET           = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SET           = 3'd5;
  localparam logic [CMD_W-1:0] CMD_FIND          = 3'd6;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [POS_W-1:0] position_out;
    logic [VAL_W-1:0] read_value;
    logic [POS_W-1:0] removed_count;
    logic [POS_W-1:0] item_count;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;     // latch a new request
    logic walk_fwd;   // read upward through held items, one per cycle
    logic walk_back;  // read downward from the top, shifting items up
    logic scan_end;   // close a search and set the insert position
    logic put_value;  // write the request value and grow the count
    logic drop;       // shrink the count after an erase
    logic commit;     // take the compacted count
    logic get_read;   // read the addressed item
    logic get_cap;    // capture the read item
    logic set_write;  // overwrite the addressed item
    logic load_rsp;   // load the response register
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic chk_ok;     // request passes its range and fullness check
    logic hit;        // search matched on the item returned this cycle
    logic fwd_done;   // upward walk finished, nothing in flight
    logic back_done;  // downward walk reached the insert position
  } sts_t;

endpackage

### src/bounded_sequence_store.sv
// Bounded sequence store: ordered list of up to DEPTH items held in one RAM.
// Top level joining the controller and the datapath; depends on bsq_pkg,
// bsq_ctrl, bsq_dpath and bsq_ram.
//
// req channel (req_valid / req_stall / req) carries one operation: cmd,
// position and value; a transfer takes place when req_valid is high and
// req_stall is low. One response per request leaves on the rsp channel
// (rsp_valid / rsp_stall / rsp) in request order. cfg channel (cfg_valid /
// cfg_ready / cfg_data) writes the capacity limit; cfg_ready is always high.
// Write it only while no request is in flight.
// Walks move one item per cycle through the single RAM read port, and one
// request is worked on at a time. Reset empties the store and sets capacity
// to 64; item storage is not cleared. A response held under rsp_stall stays
// in the output register while the next request is worked on; that request
// finishes once the output register is free.
`timescale 1ns / 1ps

module bounded_sequence_store #(
  parameter int DEPTH      = bsq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = bsq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  bsq_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output bsq_pkg::rsp_t             rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bsq_pkg::CAP_W-1:0] cfg_data
);

  bsq_pkg::ctl_t ctl;
  bsq_pkg::sts_t sts;

  // Capacity writes are never held off
  assign cfg_ready = 1'b1;

  bsq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_cmd   (req.cmd),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  bsq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sts       (sts),
    .rsp       (rsp)
  );

endmodule

### src/bsq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bsq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/bsq_dpath.sv
// Datapath of the bounded sequence store: item RAM, count, walk pointers,
// capacity register and response register. Depends on bsq_pkg and bsq_ram.
`timescale 1ns / 1ps

module bsq_dpath #(
  parameter int DEPTH      = bsq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = bsq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bsq_pkg::req_t              req,
  input  logic                       cfg_valid,
  input  logic [bsq_pkg::CAP_W-1:0]  cfg_data,
  input  bsq_pkg::ctl_t              ctl,
  output bsq_pkg::sts_t              sts,
  output bsq_pkg::rsp_t              rsp
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > bsq_pkg::POS_W) ? CNT_W : bsq_pkg::POS_W;

  // Control state
  logic [bsq_pkg::CAP_W-1:0] cap;
  logic [CNT_W-1:0]          tot;
  logic                      pend;

  // Operation and walk registers
  logic [bsq_pkg::CMD_W-1:0] op_cmd;
  logic [DATA_WIDTH-1:0]     op_val;
  logic [CNT_W-1:0]          op_pos;
  logic [CNT_W-1:0]          ptr;
  logic [CNT_W-1:0]          pend_idx;
  logic [CNT_W-1:0]          wptr;
  logic [CNT_W-1:0]          rm_cnt;
  logic                      res_ok;
  logic [CNT_W-1:0]          res_pos;
  logic [DATA_WIDTH-1:0]     rd_val;

  // RAM ports
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // Request checks
  logic [CW-1:0]    pos_w;
  logic [CW-1:0]    tot_w;
  logic [CW-1:0]    cap_w;
  logic [CW-1:0]    lim_w;
  logic             full;
  logic             chk_ok;
  logic [CNT_W-1:0] ptr_init;

  // Walk helpers
  logic             fwd_issue;
  logic             back_issue;
  logic [CNT_W-1:0] ptr_dec;
  logic             val_le;
  logic             val_eq;
  logic             hit;
  logic [CNT_W-1:0] end_pos;

  assign pos_w = CW'(req.position);
  assign tot_w = CW'(tot);
  assign cap_w = CW'(cap);
  assign lim_w = (cap_w > CW'(DEPTH)) ? CW'(DEPTH) : cap_w;
  assign full  = (tot_w >= lim_w);

  // Check the request against the count and the capacity limit
  always_comb begin
    case (req.cmd)
      bsq_pkg::CMD_INSERT_SORTED: chk_ok = !full;
      bsq_pkg::CMD_INSERT_AT:     chk_ok = !full && (pos_w <= tot_w);
      bsq_pkg::CMD_ERASE_AT:      chk_ok = (pos_w < tot_w);
      bsq_pkg::CMD_REMOVE_EQUAL:  chk_ok = 1'b1;
      bsq_pkg::CMD_GET:           chk_ok = (pos_w < tot_w);
      bsq_pkg::CMD_SET:           chk_ok = (pos_w < tot_w);
      bsq_pkg::CMD_FIND:          chk_ok = 1'b1;
      default:                    chk_ok = 1'b0;
    endcase
  end

  // Starting pointer: top of the list for insert at, one past the hole for erase
  always_comb begin
    case (req.cmd)
      bsq_pkg::CMD_INSERT_AT: ptr_init = tot;
      bsq_pkg::CMD_ERASE_AT:  ptr_init = CNT_W'(req.position) + 1'b1;
      default:                ptr_init = '0;
    endcase
  end

  assign fwd_issue  = (ptr < tot);
  assign back_issue = (ptr != op_pos);
  assign ptr_dec    = ptr - 1'b1;
  assign val_le     = (op_val <= ram_rdata);
  assign val_eq     = (op_val == ram_rdata);
  assign hit        = pend && ((op_cmd == bsq_pkg::CMD_INSERT_SORTED) ? val_le : val_eq);
  assign end_pos    = hit ? pend_idx : tot;

  assign sts.chk_ok    = chk_ok;
  assign sts.hit       = hit;
  assign sts.fwd_done  = !fwd_issue && !pend;
  assign sts.back_done = !back_issue && !pend;

  // Read port select
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (ctl.get_read) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(op_pos);
    end else if (ctl.walk_fwd && fwd_issue) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(ptr);
    end else if (ctl.walk_back && back_issue) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(ptr_dec);
    end
  end

  // Write port select: request value, shifted item or kept item
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    if (ctl.set_write || ctl.put_value) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(op_pos);
      ram_wdata = op_val;
    end else if (ctl.walk_fwd && pend && (op_cmd == bsq_pkg::CMD_ERASE_AT)) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(pend_idx - 1'b1);
    end else if (ctl.walk_fwd && pend && (op_cmd == bsq_pkg::CMD_REMOVE_EQUAL) && !val_eq) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(wptr);
    end else if (ctl.walk_back && pend) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(pend_idx + 1'b1);
    end
  end

  bsq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Hold capacity, item count and the in-flight read flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cap  <= bsq_pkg::CAP_RESET;
      tot  <= '0;
      pend <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap <= cfg_data;
      end
      if (ctl.accept || ctl.scan_end) begin
        pend <= 1'b0;
      end else if (ctl.walk_fwd) begin
        pend <= fwd_issue;
      end else if (ctl.walk_back) begin
        pend <= back_issue;
      end
      if (ctl.put_value) begin
        tot <= tot + 1'b1;
      end
      if (ctl.drop) begin
        tot <= tot - 1'b1;
      end
      if (ctl.commit) begin
        tot <= wptr;
      end
    end
  end

  // Advance operation registers and build the response
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op_cmd  <= req.cmd;
      op_val  <= DATA_WIDTH'(req.value);
      op_pos  <= CNT_W'(req.position);
      ptr     <= ptr_init;
      wptr    <= '0;
      rm_cnt  <= '0;
      res_ok  <= (req.cmd == bsq_pkg::CMD_FIND) ? 1'b0 : chk_ok;
      res_pos <= (req.cmd == bsq_pkg::CMD_INSERT_AT) ? CNT_W'(req.position) : '0;
      rd_val  <= '0;
    end
    if (ctl.walk_fwd) begin
      pend_idx <= ptr;
      if (fwd_issue && !ctl.scan_end) begin
        ptr <= ptr + 1'b1;
      end
      if (pend && (op_cmd == bsq_pkg::CMD_REMOVE_EQUAL)) begin
        if (val_eq) begin
          rm_cnt <= rm_cnt + 1'b1;
        end else begin
          wptr <= wptr + 1'b1;
        end
      end
    end
    if (ctl.walk_back) begin
      pend_idx <= ptr_dec;
      if (back_issue) begin
        ptr <= ptr_dec;
      end
    end
    // Close a search; overrides the walk step of the same cycle
    if (ctl.scan_end) begin
      op_pos  <= end_pos;
      res_pos <= end_pos;
      ptr     <= tot;
      if (op_cmd == bsq_pkg::CMD_FIND) begin
        res_ok <= hit;
      end
    end
    if (ctl.get_cap) begin
      rd_val <= ram_rdata;
    end
    if (ctl.load_rsp) begin
      rsp.ok            <= res_ok;
      rsp.position_out  <= res_ok ? bsq_pkg::POS_W'(res_pos) : '0;
      rsp.read_value    <= bsq_pkg::VAL_W'(rd_val);
      rsp.removed_count <= bsq_pkg::POS_W'(rm_cnt);
      rsp.item_count    <= bsq_pkg::POS_W'(tot);
    end
  end

endmodule

### src/bsq_ctrl.sv
// Controller of the bounded sequence store: sequences each request through
// its search, shift, compaction, read or write steps and owns the response valid flag.
// Depends on bsq_pkg.
`timescale 1ns / 1ps

module bsq_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic [bsq_pkg::CMD_W-1:0] req_cmd,
  output logic                      req_stall,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  input  bsq_pkg::sts_t             sts,
  output bsq_pkg::ctl_t             ctl
);

  typedef enum logic [3:0] {
    IDLE,
    SCAN_INS,
    SCAN_FIND,
    SHIFT_UP,
    SHIFT_DN,
    COMPACT,
    GET_RD,
    GET_CAP,
    SET_WR,
    DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   rsp_free;

  assign req_stall = (state != IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Commands and next state
  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (req_valid) begin
          ctl.accept = 1'b1;
          case (req_cmd)
            bsq_pkg::CMD_INSERT_SORTED: state_next = sts.chk_ok ? SCAN_INS : DONE;
            bsq_pkg::CMD_INSERT_AT:     state_next = sts.chk_ok ? SHIFT_UP : DONE;
            bsq_pkg::CMD_ERASE_AT:      state_next = sts.chk_ok ? SHIFT_DN : DONE;
            bsq_pkg::CMD_REMOVE_EQUAL:  state_next = COMPACT;
            bsq_pkg::CMD_GET:           state_next = sts.chk_ok ? GET_RD : DONE;
            bsq_pkg::CMD_SET:           state_next = sts.chk_ok ? SET_WR : DONE;
            bsq_pkg::CMD_FIND:          state_next = SCAN_FIND;
            default:                    state_next = DONE;
          endcase
        end
      end
      SCAN_INS: begin
        ctl.walk_fwd = 1'b1;
        if (sts.hit || sts.fwd_done) begin
          ctl.scan_end = 1'b1;
          state_next   = SHIFT_UP;
        end
      end
      SCAN_FIND: begin
        ctl.walk_fwd = 1'b1;
        if (sts.hit || sts.fwd_done) begin
          ctl.scan_end = 1'b1;
          state_next   = DONE;
        end
      end
      SHIFT_UP: begin
        ctl.walk_back = 1'b1;
        if (sts.back_done) begin
          ctl.put_value = 1'b1;
          state_next    = DONE;
        end
      end
      SHIFT_DN: begin
        ctl.walk_fwd = 1'b1;
        if (sts.fwd_done) begin
          ctl.drop   = 1'b1;
          state_next = DONE;
        end
      end
      COMPACT: begin
        ctl.walk_fwd = 1'b1;
        if (sts.fwd_done) begin
          ctl.commit = 1'b1;
          state_next = DONE;
        end
      end
      GET_RD: begin
        ctl.get_read = 1'b1;
        state_next   = GET_CAP;
      end
      GET_CAP: begin
        ctl.get_cap = 1'b1;
        state_next  = DONE;
      end
      SET_WR: begin
        ctl.set_write = 1'b1;
        state_next    = DONE;
      end
      DONE: begin
        if (rsp_free) begin
          ctl.load_rsp = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // Hold state and the response valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
